[rtl/kmp_substring_search_assert.svh]
// Assertion macros used by the block's checker.
`ifndef KMP_SUBSTRING_SEARCH_ASSERT_SVH
`define KMP_SUBSTRING_SEARCH_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define KMP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmp assertion failed");

// Next-cycle implication, off while reset is high.
`define KMP_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmp assertion failed");

// Condition that must hold in the cycle after reset is sampled high.
`define KMP_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
    else $error("kmp assertion failed");

`endif

[rtl/kmp_pkg.sv]
// Package: constants, codes, control types and the pattern byte select.
`timescale 1ns / 1ps
package kmp_pkg;

  localparam int MAX_PATTERN_DEF = 16;
  localparam int MAX_TEXT_DEF    = 65536;
  localparam int PAT_BYTES       = 16;
  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 5;
  localparam int FROM_W          = 16;
  localparam int POS_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } kmp_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD_INIT,
    ST_BUILD_CMP,
    ST_BUILD_WAIT,
    ST_STEP,
    ST_MATCH,
    ST_MATCH_WAIT,
    ST_EMIT
  } kmp_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;          // latch the incoming byte
    logic build_start;   // failure entry 0, k = 1, b = 0
    logic build_adv;     // write failure entry k, advance k
    logic b_load;        // b from failure table read
    logic pos_step;      // capture and advance the text position
    logic j_fall;        // read failure entry j-1
    logic j_load;        // j from failure table read
    logic j_adv;         // advance j on a byte compare
    logic finish;        // end the search, stage a result
    logic finish_found;
    logic out_load;      // move staged result to the output register
  } kmp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start;
    logic done;
    logic len_one;
    logic build_last;
    logic b_miss;
    logic over;
    logic in_range;
    logic eot;
    logic j_miss;
    logic j_hit;
    logic out_free;
  } kmp_stat_t;

  // Pattern byte idx; bytes beyond the sixteenth read as zero.
  function automatic logic [BYTE_W-1:0] pat_byte(input logic [8*PAT_BYTES-1:0] pat,
                                                 input logic [6:0] idx);
    logic [BYTE_W-1:0] r;
    r = '0;
    if (idx < 7'(PAT_BYTES)) begin
      r = pat[{idx[3:0], 3'b000} +: BYTE_W];
    end
    return r;
  endfunction

endpackage

[rtl/kmp_channels.sv]
// Valid/ready channel interfaces for text bytes and search results.
`timescale 1ns / 1ps
interface kmp_text_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        start_of_text;
  logic        end_of_text;
  logic [15:0] search_from;

  modport source (output valid, text_byte, start_of_text, end_of_text, search_from,
                  input ready);
  modport sink   (input valid, text_byte, start_of_text, end_of_text, search_from,
                  output ready);
endinterface

interface kmp_result_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

[rtl/kmp_ram.sv]
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kmp_ctrl.sv]
// Controller: sequences failure table build, byte matching and result hand-off.
`timescale 1ns / 1ps
module kmp_ctrl
  import kmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      ready,
  input  kmp_stat_t stat,
  output kmp_cmd_t  cmd
);

  kmp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        // hold off transfers while reset is high
        ready = !rst;
        if (in_valid && !rst) begin
          cmd.take = 1'b1;
          if (stat.start) begin
            state_next = ST_BUILD_INIT;
          end else if (!stat.done) begin
            state_next = ST_STEP;
          end
        end
      end
      ST_BUILD_INIT: begin
        cmd.build_start = 1'b1;
        state_next = stat.len_one ? ST_STEP : ST_BUILD_CMP;
      end
      ST_BUILD_CMP: begin
        if (stat.b_miss) begin
          state_next = ST_BUILD_WAIT;
        end else begin
          cmd.build_adv = 1'b1;
          if (stat.build_last) begin
            state_next = ST_STEP;
          end
        end
      end
      ST_BUILD_WAIT: begin
        cmd.b_load = 1'b1;
        state_next = ST_BUILD_CMP;
      end
      ST_STEP: begin
        cmd.pos_step = 1'b1;
        if (stat.over) begin
          cmd.finish = 1'b1;
          state_next = ST_EMIT;
        end else if (stat.in_range) begin
          state_next = ST_MATCH;
        end else if (stat.eot) begin
          cmd.finish = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MATCH: begin
        if (stat.j_miss) begin
          cmd.j_fall = 1'b1;
          state_next = ST_MATCH_WAIT;
        end else begin
          cmd.j_adv = 1'b1;
          if (stat.j_hit) begin
            cmd.finish       = 1'b1;
            cmd.finish_found = 1'b1;
            state_next = ST_EMIT;
          end else if (stat.eot) begin
            cmd.finish = 1'b1;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_MATCH_WAIT: begin
        cmd.j_load = 1'b1;
        state_next = ST_MATCH;
      end
      ST_EMIT: begin
        // hold until the output register can take the result
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/kmp_datapath.sv]
// Datapath: pattern registers, failure table, match counters and result register.
`timescale 1ns / 1ps
module kmp_datapath
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  start_of_text,
  input  logic                  end_of_text,
  input  logic [FROM_W-1:0]     search_from,
  input  kmp_cmd_t              cmd,
  output kmp_stat_t             stat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [POS_W-1:0]      match_position
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int TP_W  = $clog2(MAX_TEXT + 1);
  localparam int CMP_W = (TP_W > FROM_W) ? TP_W : FROM_W;

  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [8*PAT_BYTES-1:0] pat;

  logic [BYTE_W-1:0] cur_byte;
  logic              eot_q;
  logic [FROM_W-1:0] from_q;
  logic [TP_W-1:0]   pos;
  logic [POS_W-1:0]  pos_cur;
  logic [CNT_W-1:0]  j, b, k, m;
  logic              done;
  logic              stage_found;
  logic [POS_W-1:0]  stage_pos;

  logic [BYTE_W-1:0] pk, pb, pj;
  logic              b_eq, j_eq;
  logic [CNT_W-1:0]  b_new, j_new, b_dec, j_dec;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [CNT_W-1:0]  ram_wdata, ram_rdata;

  assign pat = {pattern_high, pattern_low};

  // Clamp the programmed length into 1..MAX_PATTERN.
  always_comb begin
    if (pattern_length == '0) begin
      m = CNT_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      m = CNT_W'(MAX_PATTERN);
    end else begin
      m = CNT_W'(pattern_length);
    end
  end

  assign pk    = pat_byte(pat, 7'(k));
  assign pb    = pat_byte(pat, 7'(b));
  assign pj    = pat_byte(pat, 7'(j));
  assign b_eq  = (pk == pb);
  assign j_eq  = (cur_byte == pj);
  assign b_new = b + CNT_W'(b_eq);
  assign j_new = j + CNT_W'(j_eq);
  assign b_dec = b - CNT_W'(1);
  assign j_dec = j - CNT_W'(1);

  assign ram_we    = cmd.build_start | cmd.build_adv;
  assign ram_waddr = cmd.build_start ? '0 : k[IDX_W-1:0];
  assign ram_wdata = cmd.build_start ? '0 : b_new;
  assign ram_raddr = cmd.j_fall ? j_dec[IDX_W-1:0] : b_dec[IDX_W-1:0];

  kmp_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_PATTERN)
  ) u_failure_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.start      = start_of_text;
    stat.done       = done;
    stat.len_one    = (m == CNT_W'(1));
    stat.build_last = ((k + CNT_W'(1)) == m);
    stat.b_miss     = (b != '0) && !b_eq;
    stat.over       = (pos >= TP_W'(MAX_TEXT));
    stat.in_range   = (CMP_W'(pos) >= CMP_W'(from_q));
    stat.eot        = eot_q;
    stat.j_miss     = (j != '0) && !j_eq;
    stat.j_hit      = (j_new >= m);
    stat.out_free   = !out_valid || out_ready;
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
      done           <= 1'b1;
      j              <= '0;
      pos            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (kmp_reg_t'(cfg_index))
          REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
          REG_PATTERN_LOW:    pattern_low    <= cfg_data;
          REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.take && start_of_text) begin
        j    <= '0;
        pos  <= '0;
        done <= 1'b0;
      end
      if (cmd.pos_step) begin
        if (!stat.over) begin
          pos <= pos + TP_W'(1);
        end
        // drop a count left over from a longer pattern
        if (j >= m) begin
          j <= '0;
        end
      end
      if (cmd.j_load) begin
        j <= ram_rdata;
      end
      if (cmd.j_adv) begin
        j <= j_new;
      end
      if (cmd.finish) begin
        done <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur_byte <= text_byte;
      eot_q    <= end_of_text;
      from_q   <= search_from;
    end
    if (cmd.build_start) begin
      k <= CNT_W'(1);
      b <= '0;
    end
    if (cmd.build_adv) begin
      b <= b_new;
      k <= k + CNT_W'(1);
    end
    if (cmd.b_load) begin
      b <= ram_rdata;
    end
    if (cmd.pos_step) begin
      pos_cur <= POS_W'(pos);
    end
    if (cmd.finish) begin
      stage_found <= cmd.finish_found;
      stage_pos   <= cmd.finish_found ? (pos_cur + POS_W'(1) - POS_W'(m)) : '0;
    end
    if (cmd.out_load) begin
      found          <= stage_found;
      match_position <= stage_pos;
    end
  end

endmodule

[rtl/kmp_substring_search.sv]
// Top level: KMP substring search over a streamed text.
`timescale 1ns / 1ps
// Finds the first occurrence of the programmed pattern (1 to MAX_PATTERN bytes)
// in a text streamed one byte per transfer, and returns one result per text:
// found with the match start index, or not-found at the last byte or once the
// text passes MAX_TEXT bytes. Program the pattern registers only between
// texts. A byte at or past the start position is accepted, steps the position
// and is compared, plus a failure table read and compare per link followed;
// links amortize to under one per byte. A byte before the start position is
// accepted and steps the position only; a byte that arrives while no search is
// active is only accepted. The first byte of a text also rebuilds the failure
// table first, one entry per pattern byte plus a reload per link followed. A
// byte that ends the search also loads the output register, waiting while the
// previous result still sits there; the loaded result then waits for the sink
// while the next byte is taken. This follows from the single-read failure
// table RAM with registered output and the matcher's one compare per cycle.
module kmp_substring_search
  import kmp_pkg::*;
#(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int MAX_TEXT    = MAX_TEXT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  kmp_text_if.sink              text,
  kmp_result_if.source          result
);

  kmp_cmd_t  cmd;
  kmp_stat_t stat;

  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .ready    (text.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kmp_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_TEXT    (MAX_TEXT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .text_byte      (text.text_byte),
    .start_of_text  (text.start_of_text),
    .end_of_text    (text.end_of_text),
    .search_from    (text.search_from),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .found          (result.found),
    .match_position (result.match_position)
  );

endmodule

[rtl/kmp_checker.sv]
// Checker on the result port of the search block, bound to the top level.
`timescale 1ns / 1ps
`include "kmp_substring_search_assert.svh"
module kmp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic        found,
  input logic [15:0] match_position
);

  `KMP_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !result_valid)
  `KMP_ASSERT_NXT(a_valid_hold, clk, rst, result_valid && !result_ready, result_valid)
  `KMP_ASSERT_NXT(a_payload_hold, clk, rst, result_valid && !result_ready, $stable(found) && $stable(match_position))
  `KMP_ASSERT_IMP(a_miss_zero, clk, rst, result_valid && !found, match_position == 16'd0)

endmodule

bind kmp_substring_search kmp_checker u_kmp_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .found          (result.found),
  .match_position (result.match_position)
);
